[rtl/core/ofm_pkg.sv]
// ----------------------------------------------------------------------------
// ofm_pkg
// Shared types and constants for the ones-complement float multiply core.
// ----------------------------------------------------------------------------
package ofm_pkg;

    // word and mantissa geometry
    localparam int WORD_W  = 24;
    localparam int MANT_W  = 72;
    localparam int N_CELLS = MANT_W / WORD_W;
    localparam int PROD_W  = 2 * MANT_W;
    localparam int CHR_W   = 25;

    // characteristic limits and bias
    localparam logic [22:0]      CHAR_MAX  = 23'h7FFFFF;
    localparam logic [CHR_W-1:0] CHAR_BIAS = 25'h0400000;

    // register reset values
    localparam logic [WORD_W-1:0] GUARD_RESET = 24'hC00000;

    // configuration register indexes
    localparam logic [1:0] REG_GUARD   = 2'd0;
    localparam logic [1:0] REG_RESIDUE = 2'd1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIN,
        ST_NORM
    } t_state;

endpackage

[rtl/core/ones_complement_float_multiply_core.sv]
// An accepted item passes through the multiply steps, ST_FIN and ST_NORM (up
// to 72 residue normalising shifts) before the one-cycle o_done strobe.
// No new item is taken while busy; the 72-step shift-add through the row of
// three 24-bit cells and the one-bit-per-cycle residue shifter fill that time.
// Reset: synchronous, active low; returns to idle, resets control and config.
// The o_done strobe is high for a single cycle and the receiver cannot stall.
// ----------------------------------------------------------------------------
// ones_complement_float_multiply_core
// 96-bit ones-complement float multiply with optional residue float.
// ----------------------------------------------------------------------------
module ones_complement_float_multiply_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic [23:0] i_acc_word0,
    input  logic [23:0] i_acc_word1,
    input  logic [23:0] i_acc_word2,
    input  logic [23:0] i_acc_word3,
    input  logic [23:0] i_mult_word0,
    input  logic [23:0] i_mult_word1,
    input  logic [23:0] i_mult_word2,
    input  logic [23:0] i_mult_word3,
    output logic        o_done,
    output logic [23:0] o_prod_word0,
    output logic [23:0] o_prod_word1,
    output logic [23:0] o_prod_word2,
    output logic [23:0] o_prod_word3,
    output logic [23:0] o_minor_word0,
    output logic [23:0] o_minor_word1,
    output logic [23:0] o_minor_word2,
    output logic [23:0] o_minor_word3,
    output logic        o_status
);

    localparam int W  = ofm_pkg::WORD_W;
    localparam int MW = ofm_pkg::MANT_W;
    localparam int NC = ofm_pkg::N_CELLS;
    localparam int PW = ofm_pkg::PROD_W;
    localparam int CW = ofm_pkg::CHR_W;
    localparam logic [6:0] LAST_STEP = 7'(MW - 1);
    localparam logic [6:0] MAX_SHIFT = 7'(MW);

    ofm_pkg::t_state r_state, n_state;

    // configuration registers
    logic [W-1:0] r_guard;
    logic         r_residue;

    // item registers
    logic          r_sign;
    logic          r_ok;
    logic [CW-1:0] r_chr;
    logic [6:0]    r_cnt;
    logic [22:0]   r_pchr;
    logic          r_stat;
    logic [MW-1:0] r_mant;
    logic [MW-1:0] r_res;
    logic [6:0]    r_n;

    // control from the sequencer
    logic c_load, c_step, c_fin, c_shift, c_out;

    // operand preparation
    logic          w_sa, w_sm;
    logic [W-1:0]  w_a0, w_m0;
    logic [MW-1:0] w_amant, w_mmant;

    assign w_sa    = i_acc_word0[W-1];
    assign w_sm    = i_mult_word0[W-1];
    assign w_a0    = i_acc_word0 ^ {W{w_sa}};
    assign w_m0    = i_mult_word0 ^ {W{w_sm}};
    assign w_amant = {i_acc_word1, i_acc_word2, i_acc_word3} ^ {MW{w_sa}};
    assign w_mmant = {i_mult_word1, i_mult_word2, i_mult_word3} ^ {MW{w_sm}};

    // row of multiplier cells, cell 0 least significant
    logic          w_cout [NC];
    logic          w_slsb [NC];
    logic          w_llsb [NC];
    logic [W-1:0]  w_acc  [NC];
    logic [W-1:0]  w_lo   [NC];
    logic [MW-1:0] w_phi, w_plo;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        logic l_cin, l_ains, l_lins;
        if (k == 0) begin : g_lo
            assign l_cin = 1'b0;
        end else begin : g_mid
            assign l_cin = w_cout[k-1];
        end
        if (k == NC - 1) begin : g_top
            assign l_ains = w_cout[k];
            assign l_lins = w_slsb[0];
        end else begin : g_inner
            assign l_ains = w_slsb[k+1];
            assign l_lins = w_llsb[k+1];
        end
        ofm_cell u_cell (
            .i_clk     (i_clk),
            .i_load    (c_load),
            .i_step    (c_step),
            .i_mcand   (w_amant[k*W +: W]),
            .i_mplier  (w_mmant[k*W +: W]),
            .i_add     (w_llsb[0]),
            .i_cin     (l_cin),
            .i_acc_ins (l_ains),
            .i_lo_ins  (l_lins),
            .o_cout    (w_cout[k]),
            .o_sum_lsb (w_slsb[k]),
            .o_lo_lsb  (w_llsb[k]),
            .o_acc     (w_acc[k]),
            .o_lo      (w_lo[k])
        );
        assign w_phi[k*W +: W] = w_acc[k];
        assign w_plo[k*W +: W] = w_lo[k];
    end

    // rounding or normalising shift of the full product
    logic [PW-1:0]   f_p, f_q;
    logic [96:0]     f_rsum;
    logic [MW-1:0]   f_mant, f_res;
    logic [CW-1:0]   f_chr;
    logic            f_sat;

    always_comb begin
        f_p    = {w_phi, w_plo};
        f_q    = {f_p[PW-2:0], 1'b0};
        f_rsum = {1'b0, f_p[PW-1:PW-96]} + {73'd0, r_guard};
        f_mant = '0;
        f_res  = '0;
        f_chr  = '0;
        if (!r_ok) begin
            f_chr = '0;
        end else if (f_p[PW-1]) begin
            f_res = f_p[MW-1:0];
            if (r_residue) begin
                f_mant = f_p[PW-1:MW];
                f_chr  = r_chr;
            end else if (f_rsum[96]) begin
                f_mant = {1'b1, {(MW-1){1'b0}}};
                f_chr  = r_chr + 25'd1;
            end else begin
                f_mant = f_rsum[95:24];
                f_chr  = r_chr;
            end
        end else begin
            f_mant = f_q[PW-1:MW];
            f_res  = f_q[MW-1:0];
            f_chr  = r_chr - 25'd1;
        end
        f_sat = r_ok && (f_chr[CW-1] || f_chr[CW-2]);
    end

    // residue characteristic and result words
    logic [CW-1:0] o_c;
    logic          o_bad;
    logic [W-1:0]  o_smask;
    logic [W-1:0]  o_m0;
    logic [MW-1:0] o_mm;

    always_comb begin
        o_smask = {W{r_sign}};
        o_c     = {2'b00, r_pchr} - 25'(MW) - {18'd0, r_n};
        if (r_n == MAX_SHIFT) begin
            o_c = '0;
        end
        o_bad = o_c[CW-1] || o_c[CW-2];
        if (!r_residue) begin
            o_m0 = '0;
            o_mm = '0;
        end else if (o_bad) begin
            o_m0 = o_smask;
            o_mm = {MW{r_sign}};
        end else begin
            o_m0 = o_c[W-1:0] ^ o_smask;
            o_mm = r_res ^ {MW{r_sign}};
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ofm_pkg::ST_IDLE: if (start) n_state = ofm_pkg::ST_MUL;
            ofm_pkg::ST_MUL:  if (r_cnt == LAST_STEP) n_state = ofm_pkg::ST_FIN;
            ofm_pkg::ST_FIN:  n_state = ofm_pkg::ST_NORM;
            ofm_pkg::ST_NORM: begin
                if (!r_residue || r_res[MW-1] || r_n == MAX_SHIFT) begin
                    n_state = ofm_pkg::ST_IDLE;
                end
            end
            default: n_state = ofm_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        c_load  = 1'b0;
        c_step  = 1'b0;
        c_fin   = 1'b0;
        c_shift = 1'b0;
        c_out   = 1'b0;
        unique case (r_state)
            ofm_pkg::ST_IDLE: c_load = start;
            ofm_pkg::ST_MUL:  c_step = 1'b1;
            ofm_pkg::ST_FIN:  c_fin  = 1'b1;
            ofm_pkg::ST_NORM: begin
                if (!r_residue || r_res[MW-1] || r_n == MAX_SHIFT) begin
                    c_out = 1'b1;
                end else begin
                    c_shift = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign busy = (r_state != ofm_pkg::ST_IDLE);

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ofm_pkg::ST_IDLE;
            r_guard   <= ofm_pkg::GUARD_RESET;
            r_residue <= 1'b0;
            r_cnt     <= '0;
            o_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= c_out;
            if (c_load) begin
                r_cnt <= '0;
            end else if (c_step) begin
                r_cnt <= r_cnt + 7'd1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ofm_pkg::REG_GUARD:   r_guard   <= i_cfg_data;
                    ofm_pkg::REG_RESIDUE: r_residue <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // item datapath
    always_ff @(posedge i_clk) begin
        if (c_load) begin
            r_sign <= w_sa ^ w_sm;
            r_ok   <= w_amant[MW-1] & w_mmant[MW-1];
            r_chr  <= {2'b00, w_a0[22:0]} + {2'b00, w_m0[22:0]} - ofm_pkg::CHAR_BIAS;
        end
        if (c_fin) begin
            r_mant <= f_mant;
            r_res  <= f_res;
            r_n    <= '0;
            r_stat <= f_sat;
            r_pchr <= f_sat ? ofm_pkg::CHAR_MAX : f_chr[22:0];
        end else if (c_shift) begin
            r_res <= {r_res[MW-2:0], 1'b0};
            r_n   <= r_n + 7'd1;
        end
        if (c_out) begin
            o_prod_word0  <= {1'b0, r_pchr} ^ o_smask;
            o_prod_word1  <= r_mant[3*W-1:2*W] ^ o_smask;
            o_prod_word2  <= r_mant[2*W-1:W] ^ o_smask;
            o_prod_word3  <= r_mant[W-1:0] ^ o_smask;
            o_minor_word0 <= o_m0;
            o_minor_word1 <= o_mm[3*W-1:2*W];
            o_minor_word2 <= o_mm[2*W-1:W];
            o_minor_word3 <= o_mm[W-1:0];
            o_status      <= r_stat;
        end
    end

`ifndef NO_ASSERTIONS
    // result strobe lasts a single cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("done held");
    // an accepted item starts the multiply
    a_start_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == ofm_pkg::ST_MUL)) else $error("no start");
    // step count stays inside the mantissa
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ofm_pkg::ST_MUL) |-> (r_cnt <= LAST_STEP)) else $error("cnt");
    // normalising shift is bounded
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ofm_pkg::ST_NORM) |-> (r_n <= MAX_SHIFT)) else $error("norm");
`endif

endmodule

[rtl/core/ofm_cell.sv]
// ----------------------------------------------------------------------------
// ofm_cell
// One 24-bit slice of the shift-add multiplier: accumulator, multiplicand
// and low-product slice, shifting right into its neighbour each step.
// ----------------------------------------------------------------------------
module ofm_cell (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic                       i_step,
    input  logic [ofm_pkg::WORD_W-1:0] i_mcand,
    input  logic [ofm_pkg::WORD_W-1:0] i_mplier,
    input  logic                       i_add,
    input  logic                       i_cin,
    input  logic                       i_acc_ins,
    input  logic                       i_lo_ins,
    output logic                       o_cout,
    output logic                       o_sum_lsb,
    output logic                       o_lo_lsb,
    output logic [ofm_pkg::WORD_W-1:0] o_acc,
    output logic [ofm_pkg::WORD_W-1:0] o_lo
);

    logic [ofm_pkg::WORD_W-1:0] r_acc;
    logic [ofm_pkg::WORD_W-1:0] r_mc;
    logic [ofm_pkg::WORD_W-1:0] r_lo;
    logic [ofm_pkg::WORD_W:0]   w_sum;

    // slice add with carry from the lower neighbour
    assign w_sum = {1'b0, r_acc} + {1'b0, (i_add ? r_mc : '0)}
                 + {{ofm_pkg::WORD_W{1'b0}}, i_cin};

    assign o_cout    = w_sum[ofm_pkg::WORD_W];
    assign o_sum_lsb = w_sum[0];
    assign o_lo_lsb  = r_lo[0];
    assign o_acc     = r_acc;
    assign o_lo      = r_lo;

    // load or shift one place right
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc <= '0;
            r_mc  <= i_mcand;
            r_lo  <= i_mplier;
        end else if (i_step) begin
            r_acc <= {i_acc_ins, w_sum[ofm_pkg::WORD_W-1:1]};
            r_lo  <= {i_lo_ins, r_lo[ofm_pkg::WORD_W-1:1]};
        end
    end

endmodule

[dv/ones_complement_float_multiply_core_tb.sv]
// ----------------------------------------------------------------------------
// ones_complement_float_multiply_core_tb
// Self-checking bench for the 96-bit ones-complement float multiply core.
// Each accepted item is run through a behavioural multiplier in the bench and
// the expected product (and residue) is queued. Every o_done strobe is checked
// field by field against the oldest queued product. Directed operands come
// first, then random items under several guard and residue settings.
// ----------------------------------------------------------------------------
module ones_complement_float_multiply_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 170;
    localparam int PHASE_ITEMS   = 240;

    typedef struct packed {
        logic [23:0] prod0;
        logic [23:0] prod1;
        logic [23:0] prod2;
        logic [23:0] prod3;
        logic [23:0] minor0;
        logic [23:0] minor1;
        logic [23:0] minor2;
        logic [23:0] minor3;
        logic        sat;
    } t_product;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = ofm_pkg::REG_GUARD;
    logic [23:0] i_cfg_data = '0;
    logic [95:0] acc_bus = '0;
    logic [95:0] mult_bus = '0;
    logic        o_done;
    logic [23:0] o_prod_word0, o_prod_word1, o_prod_word2, o_prod_word3;
    logic [23:0] o_minor_word0, o_minor_word1, o_minor_word2, o_minor_word3;
    logic        o_status;

    // bench copy of the two registers
    logic [23:0] guard_word = ofm_pkg::GUARD_RESET;
    logic        residue_on = 1'b0;

    t_product    pending_products[$];
    int          n_items = 0;
    int          n_checked = 0;
    int          n_errors = 0;
    int          n_saturated = 0;
    bit          idle_enable = 1'b1;

    always #1 i_clk = ~i_clk;

    ones_complement_float_multiply_core DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_acc_word0  (acc_bus[95:72]),
        .i_acc_word1  (acc_bus[71:48]),
        .i_acc_word2  (acc_bus[47:24]),
        .i_acc_word3  (acc_bus[23:0]),
        .i_mult_word0 (mult_bus[95:72]),
        .i_mult_word1 (mult_bus[71:48]),
        .i_mult_word2 (mult_bus[47:24]),
        .i_mult_word3 (mult_bus[23:0]),
        .o_done       (o_done),
        .o_prod_word0 (o_prod_word0),
        .o_prod_word1 (o_prod_word1),
        .o_prod_word2 (o_prod_word2),
        .o_prod_word3 (o_prod_word3),
        .o_minor_word0(o_minor_word0),
        .o_minor_word1(o_minor_word1),
        .o_minor_word2(o_minor_word2),
        .o_minor_word3(o_minor_word3),
        .o_status     (o_status)
    );

    // behavioural multiply: magnitudes, exact product, round or shift, sign
    function automatic t_product multiply_float(input logic [95:0] acc,
                                                input logic [95:0] mul,
                                                input logic [23:0] guard,
                                                input logic        res_mode);
        t_product    r;
        logic [23:0] sa, sm, sg;
        logic [22:0] ca, cm;
        logic [71:0] ma, mm, minor;
        logic [143:0] prod;
        logic [191:0] v;
        logic [96:0]  sum97;
        logic [192:0] sum193;
        int          chr, rc, n;
        sa = acc[95] ? 24'hFFFFFF : 24'h0;
        sm = mul[95] ? 24'hFFFFFF : 24'h0;
        sg = sa ^ sm;
        ca = acc[94:72] ^ sa[22:0];
        cm = mul[94:72] ^ sm[22:0];
        ma = acc[71:0] ^ {3{sa}};
        mm = mul[71:0] ^ {3{sm}};
        r = '0;
        chr = 0;
        {r.prod0, r.prod1, r.prod2, r.prod3} = {4{sg}};
        minor = {3{sg}};
        if (ma[71] && mm[71]) begin
            prod = {72'd0, ma} * {72'd0, mm};
            v = {prod, 48'h0};
            chr = int'(ca) + int'(cm) - int'(ofm_pkg::CHAR_BIAS);
            if (prod[143]) begin
                // rounding word sits below the live mantissa words
                if (res_mode) begin
                    sum193 = {1'b0, v} + {169'd0, guard};
                    v = sum193[191:0];
                    if (sum193[192]) begin
                        chr++;
                        v[191:24] = {1'b1, v[191:25]};
                    end
                end else begin
                    sum97 = {1'b0, v[191:96]} + {73'd0, guard};
                    v[191:96] = sum97[95:0];
                    if (sum97[96]) begin
                        chr++;
                        v[191:120] = {1'b1, v[191:121]};
                    end
                end
            end else begin
                if (res_mode)
                    v = v << 1;
                else
                    v[191:96] = v[191:96] << 1;
                chr--;
            end
            if (chr < 0 || chr > int'(ofm_pkg::CHAR_MAX)) begin
                chr = int'(ofm_pkg::CHAR_MAX);
                r.sat = 1'b1;
            end
            v[191:48] = v[191:48] ^ {6{sg}};
            r.prod0 = sg ^ 24'(chr);
            {r.prod1, r.prod2, r.prod3} = v[191:120];
            minor = v[119:48];
        end
        // residue: normalise the low product bits into a second float
        if (res_mode) begin
            rc = chr - ofm_pkg::MANT_W;
            n = 0;
            while (n < ofm_pkg::MANT_W && !(minor[71] ^ sg[0])) begin
                minor = {minor[70:0], sg[0]};
                n++;
            end
            if (n < ofm_pkg::MANT_W)
                rc -= n;
            else
                rc = 0;
            if (rc < 0 || rc > int'(ofm_pkg::CHAR_MAX)) begin
                rc = 0;
                minor = {3{sg}};
            end
            r.minor0 = 24'(rc) ^ sg;
            {r.minor1, r.minor2, r.minor3} = minor;
        end
        return r;
    endfunction

    // build an operand from sign, characteristic and magnitude mantissa
    function automatic logic [95:0] make_operand(input logic sgn, input logic [22:0] chr,
                                                 input logic [71:0] mant);
        logic [95:0] raw;
        raw = {1'b0, chr, mant};
        return sgn ? ~raw : raw;
    endfunction

    function automatic logic [95:0] random_operand();
        logic [71:0] mant;
        logic [22:0] chr;
        logic        sgn;
        sgn = 1'($urandom_range(0, 1));
        mant = {8'($urandom()), $urandom(), $urandom()};
        // mostly normalised, some unnormalised noise
        if ($urandom_range(0, 99) < 88)
            mant[71] = 1'b1;
        case ($urandom_range(0, 9))
            0: chr = 23'($urandom_range(0, 'h7FFFFF));
            1: chr = 23'($urandom_range(0, 'h40));
            2: chr = 23'(32'h7FFFFF - $urandom_range(0, 'h40));
            3: chr = 23'(32'h200000 + $urandom_range(0, 'h40) - 32'h20);
            4: chr = 23'(32'h600000 + $urandom_range(0, 'h40) - 32'h20);
            default: chr = 23'(32'h400000 + $urandom_range(0, 'h1000) - 32'h800);
        endcase
        return make_operand(sgn, chr, mant);
    endfunction

    // send one item and queue its expected product
    task automatic send_item(input logic [95:0] acc, input logic [95:0] mul);
        int gap;
        @(negedge i_clk);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        acc_bus = acc;
        mult_bus = mul;
        start = 1'b1;
        // busy only moves at the rising edge, so its value here holds for the next edge
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        pending_products.push_back(multiply_float(acc, mul, guard_word, residue_on));
        n_items++;
    endtask

    // let every expected product drain, then give the core time to settle
    task automatic drain_products();
        @(negedge i_clk);
        start = 1'b0;
        wait (pending_products.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == ofm_pkg::REG_GUARD)
            guard_word = data;
        else if (idx == ofm_pkg::REG_RESIDUE)
            residue_on = data[0];
    endtask

    task automatic set_mode(input logic [23:0] guard, input logic res_mode);
        drain_products();
        write_reg(ofm_pkg::REG_GUARD, guard);
        write_reg(ofm_pkg::REG_RESIDUE, {23'h0, res_mode});
    endtask

    // operand extremes, saturation and unnormalised cases
    task automatic test_directed_products();
        logic [71:0] one_m, max_m;
        one_m = {1'b1, 71'h0};
        max_m = '1;
        send_item(make_operand(1'b0, 23'h400000, one_m),
                  make_operand(1'b0, 23'h400000, one_m));
        send_item(make_operand(1'b1, 23'h400001, max_m),
                  make_operand(1'b0, 23'h400000, max_m));
        send_item(make_operand(1'b1, 23'h7FFFFF, max_m),
                  make_operand(1'b1, 23'h7FFFFF, max_m));
        send_item(make_operand(1'b0, 23'h0, one_m), make_operand(1'b1, 23'h0, one_m));
        send_item(make_operand(1'b0, 23'h400000, max_m), make_operand(1'b0, 23'h0, max_m));
        send_item(make_operand(1'b0, 23'h3FFFFF, one_m),
                  make_operand(1'b0, 23'h7FFFFF, max_m));
        send_item(96'h0, 96'h0);
        send_item('1, '1);
        send_item(96'h0, make_operand(1'b0, 23'h400000, max_m));
        send_item(make_operand(1'b1, 23'h400000, 72'h7FFFFF_FFFFFF_FFFFFF),
                  make_operand(1'b0, 23'h400000, max_m));
        send_item(make_operand(1'b0, 23'h400000, {1'b1, 71'h5A5A5A_A5A5A5_0F0F0F}),
                  make_operand(1'b1, 23'h455555, {1'b1, 71'h2AAAAA_555555_3C3C3C}));
    endtask

    // guard extremes and the residue float
    task automatic test_residue_and_guard();
        logic [71:0] one_m, max_m;
        one_m = {1'b1, 71'h0};
        max_m = '1;
        set_mode(24'hFFFFFF, 1'b0);
        send_item(make_operand(1'b0, 23'h400000, max_m),
                  make_operand(1'b0, 23'h400000, max_m));
        send_item(make_operand(1'b1, 23'h400000, max_m),
                  make_operand(1'b0, 23'h400000, one_m));
        set_mode(24'h000000, 1'b0);
        send_item(make_operand(1'b0, 23'h400000, max_m),
                  make_operand(1'b1, 23'h400000, max_m));
        set_mode(24'hFFFFFF, 1'b1);
        send_item(make_operand(1'b0, 23'h400000, one_m),
                  make_operand(1'b1, 23'h400000, one_m));
        send_item(make_operand(1'b1, 23'h400000, max_m),
                  make_operand(1'b0, 23'h400000, max_m));
        send_item(make_operand(1'b0, 23'h000010, max_m),
                  make_operand(1'b0, 23'h400010, max_m));
        send_item(make_operand(1'b0, 23'h7FFFFF, max_m),
                  make_operand(1'b1, 23'h7FFFFF, max_m));
        send_item(make_operand(1'b0, 23'h400000, {1'b1, 70'h0, 1'b1}),
                  make_operand(1'b0, 23'h400000, {1'b1, 70'h0, 1'b1}));
        send_item(96'h0, make_operand(1'b1, 23'h400000, max_m));
        // unused register indexes change nothing
        drain_products();
        write_reg(2'd2, 24'hFFFFFF);
        write_reg(2'd3, 24'hFFFFFF);
        send_item(make_operand(1'b1, 23'h400123, max_m),
                  make_operand(1'b0, 23'h3FFF00, one_m));
    endtask

    task automatic test_random_products(input logic [23:0] guard, input logic res_mode,
                                        input bit with_idle);
        set_mode(guard, res_mode);
        idle_enable = with_idle;
        repeat (PHASE_ITEMS) send_item(random_operand(), random_operand());
    endtask

    // compare each strobed product with the oldest expectation
    always @(posedge i_clk) begin
        t_product want, got;
        if (i_rst_n && o_done) begin
            got = {o_prod_word0, o_prod_word1, o_prod_word2, o_prod_word3,
                   o_minor_word0, o_minor_word1, o_minor_word2, o_minor_word3, o_status};
            if (pending_products.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected product %h", got);
            end else begin
                want = pending_products.pop_front();
                n_checked++;
                n_saturated += int'(want.sat);
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("ERROR: product %0d mismatch", n_checked);
                        $display("  prod  exp %h %h %h %h got %h %h %h %h",
                                 want.prod0, want.prod1, want.prod2, want.prod3,
                                 got.prod0, got.prod1, got.prod2, got.prod3);
                        $display("  minor exp %h %h %h %h got %h %h %h %h",
                                 want.minor0, want.minor1, want.minor2, want.minor3,
                                 got.minor0, got.minor1, got.minor2, got.minor3);
                        $display("  status exp %b got %b", want.sat, got.sat);
                    end
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed_products();
        test_residue_and_guard();
        test_random_products(ofm_pkg::GUARD_RESET, 1'b0, 1'b1);
        test_random_products(24'h000000, 1'b1, 1'b1);
        test_random_products(24'hFFFFFF, 1'b0, 1'b1);
        test_random_products(24'($urandom_range(0, 'hFFFFFF)), 1'b1, 1'b1);
        test_random_products(24'($urandom_range(0, 'hFFFFFF)), 1'b0, 1'b1);
        test_random_products(ofm_pkg::GUARD_RESET, 1'b1, 1'b0);
        drain_products();
        $display("Checked %0d products from %0d items, %0d saturated, %0d mismatches",
                 n_checked, n_items, n_saturated, n_errors);
        $display("Covered guard extremes, residue on and off, signed zeros and saturation");
        if (n_errors == 0 && pending_products.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #3ms;
        $display("Timeout with %0d products outstanding", pending_products.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
